>>> hw/rtl/edfs_pkg.sv
// Shared types and constants of the earliest-deadline-first thread scheduler.
package edfs_pkg;

  localparam int ID_W = 4;
  localparam int DL_W = 31;

  typedef enum logic [1:0] {
    OP_ENQUEUE   = 2'd0,
    OP_REMOVE    = 2'd1,
    OP_SELECT    = 2'd2,
    OP_TERMINATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_READY      = 2'd0,
    ST_RUNNING    = 2'd1,
    ST_TERMINATED = 2'd2
  } thread_status_t;

  typedef enum logic [1:0] {
    RC_OK     = 2'd0,
    RC_FULL   = 2'd1,
    RC_ABSENT = 2'd2
  } rsp_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_UNLINK,
    S_INSERT,
    S_CUR_RD,
    S_CUR_CHK,
    S_PICK,
    S_PICK_WR,
    S_RESP
  } sched_state_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] thread_id;
    logic [DL_W-1:0] deadline;
  } sched_cmd_t;

  typedef struct packed {
    rsp_code_t       status_code;
    logic            chosen_valid;
    logic [ID_W-1:0] chosen_id;
    logic            switched;
  } sched_res_t;

endpackage

>>> hw/rtl/edfs_pick.sv
// Running earliest-deadline search over the table entries streamed out of the memory.
module edfs_pick import edfs_pkg::*; #(
  parameter int IW = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            cand_valid,
  input  logic [IW-1:0]   cand_id,
  input  logic [DL_W-1:0] cand_deadline,
  input  logic [IW-1:0]   cand_rank,
  output logic            found,
  output logic [IW-1:0]   best_id,
  output logic [DL_W-1:0] best_deadline,
  output logic [IW-1:0]   best_rank
);

  logic better;

  // A candidate wins on a strictly earlier deadline, or on an equal one with a lower rank.
  assign better = cand_valid &&
                  (!found || (cand_deadline < best_deadline) ||
                   ((cand_deadline == best_deadline) && (cand_rank < best_rank)));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_id       <= cand_id;
      best_deadline <= cand_deadline;
      best_rank     <= cand_rank;
    end
  end

endmodule

>>> hw/rtl/edf_thread_scheduler_unit.sv
// Earliest-deadline-first thread scheduler: thread table in one memory, scanned by a sequencer.
//
// The scheduler keeps a table of NUM_THREADS thread slots, indexed by thread id, and answers
// every command item with exactly one result item. Each slot's status, deadline and list rank
// live in a single synchronous memory with one write port and one registered read port; the
// presence bits, the entry count and the current thread are held in flip-flops, so reset clears
// the table at once and no clearing pass is needed. Commands are handled one at a time:
// cmd_ready is high only while the sequencer is idle. Remove and a re-enqueue of a present
// thread walk the whole table once to close the gap in the list ranks, and select, or an
// enqueue that preempts the current thread, walks it once more to find the ready entry with the
// earliest deadline (ties go to the lower rank). Each walk reads one entry per cycle. A command
// that fails on an absent thread goes straight to the result state, and an enqueue into a full
// table passes through the insert step first. A finished result waits in an output register,
// and the next command is taken once that result has been loaded there.
module edf_thread_scheduler_unit import edfs_pkg::*; #(
  parameter int NUM_THREADS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  sched_cmd_t cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output sched_res_t res
);

  localparam int IW = $clog2(NUM_THREADS);
  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam int XW = 9;

  typedef struct packed {
    thread_status_t  status;
    logic [DL_W-1:0] deadline;
    logic [IW-1:0]   rank;
  } entry_t;

  // Thread table: status, deadline and list rank of every slot.
  entry_t mem [NUM_THREADS];
  entry_t rd_data;
  logic            mem_re;
  logic [IW-1:0]   mem_ra;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  entry_t          mem_wd;

  sched_state_t state, state_next;

  // The command being worked on.
  op_t             op_q;
  logic [IW-1:0]   id_q;
  logic [DL_W-1:0] dl_q;
  logic [IW-1:0]   own_rank;

  // Table-wide state kept in flip-flops.
  logic [NUM_THREADS-1:0] present;
  logic [CW-1:0]          entry_count;
  logic                   cur_valid;
  logic [IW-1:0]          cur_id;

  // Table walk: cnt issues reads, rd_idx names the entry whose data has just come back.
  logic [CW-1:0] cnt;
  logic          scan_rd;
  logic          scan_last;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;

  sched_res_t rslt;

  logic [XW-1:0] cmd_wide;
  logic [IW-1:0] cmd_idx;
  logic          cmd_id_ok;
  logic          cmd_accept;
  rsp_code_t     cmd_code;
  logic          table_full;
  logic          preempt;
  logic          res_load;

  logic            pick_found;
  logic [IW-1:0]   pick_id;
  logic [DL_W-1:0] pick_deadline;
  logic [IW-1:0]   pick_rank;
  logic [XW-1:0]   pick_wide;
  logic            pick_cand;

  assign cmd_wide   = XW'(cmd.thread_id);
  assign cmd_idx    = cmd_wide[IW-1:0];
  assign cmd_id_ok  = cmd_wide < XW'(NUM_THREADS);
  assign cmd_ready  = (state == S_IDLE);
  assign cmd_accept = cmd_valid && cmd_ready;

  // Status a command earns at acceptance: an enqueue beyond the table, or a remove or
  // terminate of a thread that is not there, fails straight away.
  always_comb begin
    cmd_code = RC_OK;
    if ((cmd.op == OP_ENQUEUE) && !cmd_id_ok) begin
      cmd_code = RC_FULL;
    end else if (((cmd.op == OP_REMOVE) || (cmd.op == OP_TERMINATE)) &&
                 (!cmd_id_ok || !present[cmd_idx])) begin
      cmd_code = RC_ABSENT;
    end
  end

  assign table_full = entry_count >= CW'(NUM_THREADS);
  assign preempt    = dl_q < rd_data.deadline;
  assign scan_rd    = ((state == S_UNLINK) || (state == S_PICK)) && (cnt < CW'(NUM_THREADS));
  assign scan_last  = (cnt == CW'(NUM_THREADS));
  assign res_load   = (state == S_RESP) && (!res_valid || res_ready);
  assign pick_wide  = XW'(pick_id);

  // Only present slots that are ready take part in the earliest-deadline search.
  assign pick_cand = (state == S_PICK) && rd_vld && present[rd_idx] &&
                     (rd_data.status == ST_READY);

  edfs_pick #(
    .IW (IW)
  ) u_pick (
    .clk           (clk),
    .rst           (rst),
    .clear         (state != S_PICK),
    .cand_valid    (pick_cand),
    .cand_id       (rd_idx),
    .cand_deadline (rd_data.deadline),
    .cand_rank     (rd_data.rank),
    .found         (pick_found),
    .best_id       (pick_id),
    .best_deadline (pick_deadline),
    .best_rank     (pick_rank)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_ra     = cmd_idx;
    mem_we     = 1'b0;
    mem_wa     = id_q;
    mem_wd     = rd_data;
    unique case (state)
      S_IDLE: begin
        mem_re = cmd_valid;
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_ENQUEUE: begin
              if (!cmd_id_ok) begin
                state_next = S_RESP;
              end else if (present[cmd_idx]) begin
                state_next = S_LOOKUP;
              end else begin
                state_next = S_INSERT;
              end
            end
            OP_REMOVE, OP_TERMINATE: begin
              if (!cmd_id_ok || !present[cmd_idx]) begin
                state_next = S_RESP;
              end else begin
                state_next = S_LOOKUP;
              end
            end
            OP_SELECT: state_next = S_PICK;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_LOOKUP: begin
        if (op_q == OP_TERMINATE) begin
          mem_we        = 1'b1;
          mem_wd.status = ST_TERMINATED;
          state_next    = S_RESP;
        end else begin
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        mem_re = scan_rd;
        mem_ra = cnt[IW-1:0];
        // Entries ranked behind the unlinked one move up by one place.
        mem_wa = rd_idx;
        mem_we = rd_vld && present[rd_idx] && (rd_idx != id_q) && (rd_data.rank > own_rank);
        mem_wd.rank = rd_data.rank - 1'b1;
        if (scan_last) begin
          state_next = (op_q == OP_ENQUEUE) ? S_INSERT : S_RESP;
        end
      end
      S_INSERT: begin
        mem_we          = !table_full;
        mem_wd.status   = ST_READY;
        mem_wd.deadline = dl_q;
        mem_wd.rank     = entry_count[IW-1:0];
        if (table_full || !cur_valid) begin
          state_next = S_RESP;
        end else begin
          state_next = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        // Read in the cycle after the insert, so a current thread that was just rewritten is seen.
        mem_re     = 1'b1;
        mem_ra     = cur_id;
        state_next = S_CUR_CHK;
      end
      S_CUR_CHK: begin
        mem_wa        = cur_id;
        mem_we        = preempt;
        mem_wd.status = ST_READY;
        state_next    = preempt ? S_PICK : S_RESP;
      end
      S_PICK: begin
        mem_re = scan_rd;
        mem_ra = cnt[IW-1:0];
        if (scan_last) begin
          state_next = S_PICK_WR;
        end
      end
      S_PICK_WR: begin
        mem_wa          = pick_id;
        mem_we          = pick_found;
        mem_wd.status   = ST_RUNNING;
        mem_wd.deadline = pick_deadline;
        mem_wd.rank     = pick_rank;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Walk counter and read tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scan_rd;
      if (((state == S_UNLINK) || (state == S_PICK)) && !scan_last) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[IW-1:0];
  end

  // Table-wide control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      present     <= '0;
      entry_count <= '0;
      cur_valid   <= 1'b0;
      cur_id      <= '0;
    end else begin
      case (state)
        S_UNLINK: begin
          if (scan_last) begin
            present[id_q] <= 1'b0;
            entry_count   <= entry_count - 1'b1;
          end
        end
        S_INSERT: begin
          if (!table_full) begin
            present[id_q] <= 1'b1;
            entry_count   <= entry_count + 1'b1;
          end
        end
        S_PICK_WR: begin
          if (pick_found) begin
            cur_id <= pick_id;
            if (op_q == OP_SELECT) begin
              cur_valid <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Command capture and result assembly.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          op_q <= cmd.op;
          id_q <= cmd_idx;
          dl_q <= cmd.deadline;
          rslt <= '{status_code: cmd_code, chosen_valid: 1'b0, chosen_id: '0,
                    switched: 1'b0};
        end
      end
      S_LOOKUP: own_rank <= rd_data.rank;
      S_INSERT: begin
        if (table_full) begin
          rslt.status_code <= RC_FULL;
        end
      end
      S_PICK_WR: begin
        if (pick_found) begin
          rslt.chosen_valid <= 1'b1;
          rslt.chosen_id    <= pick_wide[ID_W-1:0];
          if ((op_q == OP_ENQUEUE) && (pick_id != cur_id)) begin
            rslt.switched <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a result waits here while the sequencer goes back to idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= rslt;
    end
  end

endmodule

>>> hw/rtl/edfs_checker.sv
// Port-level checks of the scheduler and the bind that attaches them.
module edfs_checker import edfs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input sched_cmd_t cmd,
  input logic       res_valid,
  input logic       res_ready,
  input sched_res_t res
);

  // A stalled result item holds its place and its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  // Commands are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in flight");

  // A switch is only reported together with the thread switched to.
  a_switch_chosen: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.switched |-> res.chosen_valid && (res.status_code == RC_OK))
    else $error("switch reported without a chosen thread");

  // A failed command chooses nothing, and an unchosen id reads as zero.
  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status_code != RC_OK || !res.chosen_valid) |->
      !res.chosen_valid && (res.chosen_id == '0) && !res.switched ||
      res.status_code == RC_OK && res.chosen_valid)
    else $error("failed or empty result carries a chosen thread");

endmodule

bind edf_thread_scheduler_unit edfs_checker u_edfs_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
